// ===== hdl/lyp_pkg.sv =====
package lyp_pkg;

  // Field widths
  localparam int COORD_WIDTH     = 24;
  localparam int ANGLE_WIDTH     = 16;
  localparam int MIN_LEN_WIDTH   = 8;
  localparam int MIN_LEN_RESET   = 1;

  // Difference vector and normalisation
  localparam int DIFF_WIDTH      = COORD_WIDTH + 1;
  localparam int POS_WIDTH       = $clog2(DIFF_WIDTH);
  localparam int NORM_WIDTH      = 32;
  localparam int NORM_TOP        = 30;
  localparam int SMALL_LIMIT     = 256;

  // Square root
  localparam int SUM_WIDTH       = 2 * NORM_WIDTH;
  localparam int SQRT_STAGES     = NORM_WIDTH;

  // CORDIC
  localparam int CORDIC_ITERS    = 30;
  localparam int CORDIC_IN_WIDTH = NORM_WIDTH + 2;
  localparam int XY_WIDTH        = NORM_WIDTH + 4;
  localparam int Z_WIDTH         = 34;
  localparam int TURN_HALF_SHIFT = 31;
  localparam int ANGLE_SHIFT     = 32 - ANGLE_WIDTH;

  // Scaled vector that travels beside the square root
  typedef struct packed {
    logic signed [NORM_WIDTH-1:0] sx;
    logic signed [NORM_WIDTH-1:0] sy;
    logic signed [NORM_WIDTH-1:0] sz;
    logic                         degen;
  } side_t;

  // Arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/lyp_coord_if.sv =====
interface lyp_coord_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [lyp_pkg::COORD_WIDTH-1:0]  eye_x;
  logic signed [lyp_pkg::COORD_WIDTH-1:0]  eye_y;
  logic signed [lyp_pkg::COORD_WIDTH-1:0]  eye_z;
  logic signed [lyp_pkg::COORD_WIDTH-1:0]  target_x;
  logic signed [lyp_pkg::COORD_WIDTH-1:0]  target_y;
  logic signed [lyp_pkg::COORD_WIDTH-1:0]  target_z;

  modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                  input ready);
  modport sink   (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                  output ready);
endinterface

// ===== hdl/lyp_result_if.sv =====
interface lyp_result_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [lyp_pkg::ANGLE_WIDTH-1:0]  yaw_angle;
  logic signed [lyp_pkg::ANGLE_WIDTH-1:0]  pitch_angle;
  logic                                    degenerate;

  modport source (output valid, yaw_angle, pitch_angle, degenerate, input ready);
  modport sink   (input valid, yaw_angle, pitch_angle, degenerate, output ready);
endinterface

// ===== hdl/lyp_cfg_if.sv =====
interface lyp_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [lyp_pkg::MIN_LEN_WIDTH-1:0]     data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/lyp_isqrt.sv =====
module lyp_isqrt (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  lyp_pkg::side_t                   in_side,
  output logic                             out_valid,
  output logic [lyp_pkg::NORM_WIDTH-1:0]   out_root,
  output lyp_pkg::side_t                   out_side
);
  import lyp_pkg::*;

  logic [NORM_WIDTH-1:0] hx, hz;
  logic [SUM_WIDTH-1:0]  sqx, sqz;
  logic                  va;
  side_t                 side_a;

  logic [SUM_WIDTH-1:0]  rem  [0:SQRT_STAGES];
  logic [SUM_WIDTH-1:0]  res  [0:SQRT_STAGES];
  side_t                 side [0:SQRT_STAGES];
  logic                  v    [0:SQRT_STAGES];

  assign hx = in_side.sx[NORM_WIDTH-1] ? NORM_WIDTH'(-in_side.sx) : NORM_WIDTH'(in_side.sx);
  assign hz = in_side.sz[NORM_WIDTH-1] ? NORM_WIDTH'(-in_side.sz) : NORM_WIDTH'(in_side.sz);

  // Square both horizontal parts
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
    if (en) begin
      sqx    <= SUM_WIDTH'(hx) * SUM_WIDTH'(hx);
      sqz    <= SUM_WIDTH'(hz) * SUM_WIDTH'(hz);
      side_a <= in_side;
    end
  end

  // Add the squares
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= va;
    end
    if (en) begin
      rem[0]  <= sqx + sqz;
      res[0]  <= '0;
      side[0] <= side_a;
    end
  end

  // One root bit per stage
  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_digit
    logic [SUM_WIDTH-1:0] bitv, trial;
    logic                 ge;
    assign bitv  = SUM_WIDTH'(1) << (SUM_WIDTH - 2 - 2 * i);
    assign trial = res[i] + bitv;
    assign ge    = rem[i] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
      if (en) begin
        rem[i+1]  <= ge ? rem[i] - trial : rem[i];
        res[i+1]  <= ge ? (res[i] >> 1) + bitv : res[i] >> 1;
        side[i+1] <= side[i];
      end
    end
  end

  assign out_valid = v[SQRT_STAGES];
  assign out_root  = res[SQRT_STAGES][NORM_WIDTH-1:0];
  assign out_side  = side[SQRT_STAGES];

endmodule

// ===== hdl/lyp_cordic.sv =====
module lyp_cordic (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic signed [lyp_pkg::CORDIC_IN_WIDTH-1:0] x_in,
  input  logic signed [lyp_pkg::CORDIC_IN_WIDTH-1:0] y_in,
  output logic                                   out_valid,
  output logic signed [lyp_pkg::ANGLE_WIDTH-1:0] angle
);
  import lyp_pkg::*;

  logic signed [XY_WIDTH-1:0] x    [0:CORDIC_ITERS];
  logic signed [XY_WIDTH-1:0] y    [0:CORDIC_ITERS];
  logic signed [Z_WIDTH-1:0]  z    [0:CORDIC_ITERS];
  logic                       zero [0:CORDIC_ITERS];
  logic                       v    [0:CORDIC_ITERS];

  logic signed [XY_WIDTH-1:0] xe, ye;
  logic signed [Z_WIDTH-1:0]  rounded;

  assign xe = XY_WIDTH'(x_in);
  assign ye = XY_WIDTH'(y_in);

  // Fold the left half plane over, starting from half a turn
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
    if (en) begin
      zero[0] <= (x_in == '0) && (y_in == '0);
      x[0]    <= x_in[CORDIC_IN_WIDTH-1] ? -xe : xe;
      y[0]    <= x_in[CORDIC_IN_WIDTH-1] ? -ye : ye;
      z[0]    <= x_in[CORDIC_IN_WIDTH-1] ? Z_WIDTH'(1) << TURN_HALF_SHIFT : '0;
    end
  end

  // Vectoring rotations, one per stage
  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    logic signed [XY_WIDTH-1:0] xs, ys;
    logic signed [Z_WIDTH-1:0]  step;
    logic                       up;
    assign xs   = x[i] >>> i;
    assign ys   = y[i] >>> i;
    assign step = Z_WIDTH'(atan_turn(5'(i)));
    assign up   = !y[i][XY_WIDTH-1] && (y[i] != '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
      if (en) begin
        x[i+1]    <= up ? x[i] + ys : x[i] - ys;
        y[i+1]    <= up ? y[i] - xs : y[i] + xs;
        z[i+1]    <= up ? z[i] + step : z[i] - step;
        zero[i+1] <= zero[i];
      end
    end
  end

  // Round half up to the binary angle and wrap
  assign rounded   = z[CORDIC_ITERS] + (Z_WIDTH'(1) << (ANGLE_SHIFT - 1));
  assign angle     = zero[CORDIC_ITERS] ? '0 : rounded[ANGLE_SHIFT +: ANGLE_WIDTH];
  assign out_valid = v[CORDIC_ITERS];

endmodule

// ===== hdl/look_at_yaw_pitch_unit.sv =====
// Channel | Dir | Contents
// coord   | in  | eye_x/y/z, target_x/y/z, valid/ready
// result  | out | yaw_angle, pitch_angle, degenerate, valid/ready
// cfg     | in  | data (min_length), valid/ready, always ready
//
// One transaction per cycle while no result is held; 4 front stages, 34 in the
// square root (square, sum, 32 root digits), 31 in the CORDIC, 1 output.
// Synchronous reset clears all valid bits and sets min_length to 1.
// A held result stalls the whole pipeline together; nothing is lost or repeated.
module look_at_yaw_pitch_unit (
  input  logic         clk,
  input  logic         rst,
  lyp_coord_if.sink    coord,
  lyp_result_if.source result,
  lyp_cfg_if.sink      cfg
);
  import lyp_pkg::*;

  logic                         en;
  logic [MIN_LEN_WIDTH-1:0]     min_length;

  logic                         v1, v2, v3, v4;
  logic signed [DIFF_WIDTH-1:0] dx1, dy1, dz1, dx2, dy2, dz2, dx3, dy3, dz3;
  logic                         degen2, degen3;
  logic [DIFF_WIDTH-1:0]        max2;
  logic [POS_WIDTH-1:0]         pos3;
  side_t                        side4;

  logic [DIFF_WIDTH-1:0]        ax, ay, az, mxy;
  logic                         short_vec;
  logic [17:0]                  sumsq;
  logic [2*MIN_LEN_WIDTH-1:0]   minsq;
  logic [POS_WIDTH-1:0]         pos;

  logic                         sq_valid;
  logic [NORM_WIDTH-1:0]        root;
  side_t                        sq_side;

  logic                         yaw_valid, pitch_valid;
  logic signed [ANGLE_WIDTH-1:0] yaw, pitch;
  logic                         dl [0:CORDIC_ITERS];

  logic                         out_valid;
  logic signed [ANGLE_WIDTH-1:0] out_yaw, out_pitch;
  logic                         out_degen;

  function automatic logic [DIFF_WIDTH-1:0] mag(input logic signed [DIFF_WIDTH-1:0] d);
    return d[DIFF_WIDTH-1] ? DIFF_WIDTH'(-d) : DIFF_WIDTH'(d);
  endfunction

  function automatic logic signed [NORM_WIDTH-1:0] scale(
    input logic signed [DIFF_WIDTH-1:0] d,
    input logic [POS_WIDTH-1:0]         p
  );
    logic signed [63:0] e;
    e = 64'(d);
    if (int'(p) <= NORM_TOP) begin
      e = e <<< (NORM_TOP - int'(p));
    end else begin
      e = e >>> (int'(p) - NORM_TOP);
    end
    return e[NORM_WIDTH-1:0];
  endfunction

  // Advance everything unless a result is held
  assign en          = !out_valid || result.ready;
  assign coord.ready = en;
  assign cfg.ready   = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= MIN_LEN_WIDTH'(MIN_LEN_RESET);
    end else if (cfg.valid) begin
      min_length <= cfg.data;
    end
  end

  // Stage 1: difference vector
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= coord.valid;
    end
    if (en) begin
      dx1 <= DIFF_WIDTH'(coord.target_x) - DIFF_WIDTH'(coord.eye_x);
      dy1 <= DIFF_WIDTH'(coord.target_y) - DIFF_WIDTH'(coord.eye_y);
      dz1 <= DIFF_WIDTH'(coord.target_z) - DIFF_WIDTH'(coord.eye_z);
    end
  end

  // Stage 2: length test and largest magnitude
  assign ax    = mag(dx1);
  assign ay    = mag(dy1);
  assign az    = mag(dz1);
  assign mxy   = (ay > ax) ? ay : ax;
  assign short_vec = (ax < DIFF_WIDTH'(SMALL_LIMIT)) && (ay < DIFF_WIDTH'(SMALL_LIMIT)) &&
                     (az < DIFF_WIDTH'(SMALL_LIMIT));
  assign sumsq = 18'(ax[7:0] * ax[7:0]) + 18'(ay[7:0] * ay[7:0]) + 18'(az[7:0] * az[7:0]);
  assign minsq = (2*MIN_LEN_WIDTH)'(min_length) * (2*MIN_LEN_WIDTH)'(min_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      dx2    <= dx1;
      dy2    <= dy1;
      dz2    <= dz1;
      degen2 <= short_vec && (sumsq < 18'(minsq));
      max2   <= (az > mxy) ? az : mxy;
    end
  end

  // Stage 3: position of the leading one
  always_comb begin
    pos = '0;
    for (int b = 0; b < DIFF_WIDTH; b++) begin
      if (max2[b]) begin
        pos = POS_WIDTH'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      dx3    <= dx2;
      dy3    <= dy2;
      dz3    <= dz2;
      degen3 <= degen2;
      pos3   <= pos;
    end
  end

  // Stage 4: shift all three to a common scale
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      side4.sx    <= scale(dx3, pos3);
      side4.sy    <= scale(dy3, pos3);
      side4.sz    <= scale(dz3, pos3);
      side4.degen <= degen3;
    end
  end

  lyp_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .in_side   (side4),
    .out_valid (sq_valid),
    .out_root  (root),
    .out_side  (sq_side)
  );

  lyp_cordic u_yaw (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .x_in      (-(CORDIC_IN_WIDTH'(sq_side.sz))),
    .y_in      (CORDIC_IN_WIDTH'(sq_side.sx)),
    .out_valid (yaw_valid),
    .angle     (yaw)
  );

  lyp_cordic u_pitch (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .x_in      (CORDIC_IN_WIDTH'(root)),
    .y_in      (CORDIC_IN_WIDTH'(sq_side.sy)),
    .out_valid (pitch_valid),
    .angle     (pitch)
  );

  // Carry the degenerate flag beside the CORDIC
  always_ff @(posedge clk) begin
    if (en) begin
      dl[0] <= sq_side.degen;
      for (int k = 1; k <= CORDIC_ITERS; k++) begin
        dl[k] <= dl[k-1];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= yaw_valid && pitch_valid;
    end
    if (en) begin
      out_yaw   <= dl[CORDIC_ITERS] ? '0 : yaw;
      out_pitch <= dl[CORDIC_ITERS] ? '0 : pitch;
      out_degen <= dl[CORDIC_ITERS];
    end
  end

  assign result.valid       = out_valid;
  assign result.yaw_angle   = out_yaw;
  assign result.pitch_angle = out_pitch;
  assign result.degenerate  = out_degen;

endmodule
